// ----- design/text_console_insert_engine_top_macros.svh -----
// assertion macros for the text console insert engine
`ifndef TEXT_CONSOLE_INSERT_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_INSERT_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TCI_ASSERT_NOW(label, cond_a, cond_c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_c)) \
        else $error("tci assertion failed");
`define TCI_ASSERT_NEXT(label, cond_a, cond_c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_c)) \
        else $error("tci assertion failed");
`else
`define TCI_ASSERT_NOW(label, cond_a, cond_c)
`define TCI_ASSERT_NEXT(label, cond_a, cond_c)
`endif
`endif

// ----- design/tci_pkg.sv -----
// ----------------------------------------------------------------------------
// tci_pkg
// shared types and constants of the text console insert engine
// ----------------------------------------------------------------------------
package tci_pkg;

    localparam int DEF_SCREEN_WIDTH  = 80;
    localparam int DEF_SCREEN_HEIGHT = 25;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_MASK    = 8'hFF;
    localparam logic [7:0] COLOR_RESET  = 8'd7;

    localparam int          PADDR_W       = 3;
    localparam logic [PADDR_W-1:0] REG_TEXT_COLOR = 3'd0;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_NEWLINE   = 2'd1,
        OP_BACKSPACE = 2'd2,
        OP_PRINT     = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  ch;
        logic [10:0] idx;
    } item_t;

    typedef struct packed {
        logic valid;
        item_t item;
    } queue_out_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

endpackage

// ----- design/tci_ram.sv -----
// ----------------------------------------------------------------------------
// tci_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tci_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/tci_front.sv -----
// ----------------------------------------------------------------------------
// tci_front
// accepts input transactions, classifies them, two entry queue to the back end
// ----------------------------------------------------------------------------
module tci_front
    import tci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_index,
    input  back_ctl_t   back_ctl,
    output queue_out_t  q_out
);

    item_t      slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    item_t      new_item;
    logic       push, pop;

    always_comb
    begin
        new_item.ch  = char_code;
        new_item.idx = cell_index;
        if (mode)
            new_item.op = OP_READ;
        else if (char_code == CH_NEWLINE)
            new_item.op = OP_NEWLINE;
        else if (char_code == CH_BACKSPACE)
            new_item.op = OP_BACKSPACE;
        else
            new_item.op = OP_PRINT;
    end

    assign in_ready    = (count_reg != 2'd2) && !back_ctl.clearing;
    assign push        = in_valid && in_ready;
    assign pop         = back_ctl.pop && (count_reg != 2'd0);
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= new_item;
    end

endmodule

// ----- design/tci_back.sv -----
// ----------------------------------------------------------------------------
// tci_back
// sequencer that carries out queued items on the screen memory
// ----------------------------------------------------------------------------
`include "text_console_insert_engine_top_macros.svh"
module tci_back
    import tci_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  queue_out_t q_out,
    output back_ctl_t  back_ctl,
    input  logic [7:0] text_color,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] column_now,
    output logic [4:0] row_now,
    output logic [7:0] read_char,
    output logic [7:0] read_color,
    output logic       did_scroll
);

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(SCREEN_WIDTH);
    localparam int ROW_W      = $clog2(SCREEN_HEIGHT);
    localparam int IW         = (ADDR_W > 11) ? ADDR_W : 11;
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_RD_WAIT  = 4'd2;
    localparam logic [3:0] S_BS_WAIT  = 4'd3;
    localparam logic [3:0] S_BS_GO    = 4'd4;
    localparam logic [3:0] S_PR_WAIT  = 4'd5;
    localparam logic [3:0] S_PR_WRITE = 4'd6;
    localparam logic [3:0] S_MOVE     = 4'd7;
    localparam logic [3:0] S_FILL     = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic              pend_reg, pend_next;
    logic              desc_reg, desc_next;
    logic              to_write_reg, to_write_next;
    logic              scroll_reg, scroll_next;
    item_t             cur_reg, cur_next;
    logic [7:0]        rchar_reg, rchar_next;
    logic [7:0]        rcolor_reg, rcolor_next;
    logic              out_valid_reg, out_valid_next;
    logic [6:0]        ocol_reg, ocol_next;
    logic [4:0]        orow_reg, orow_next;
    logic [7:0]        ochar_reg, ochar_next;
    logic [7:0]        ocolor_reg, ocolor_next;
    logic              oscroll_reg, oscroll_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata, mem_rdata;
    logic [ADDR_W-1:0] pos;
    logic [IW-1:0]     idx_ext;
    logic [15:0]       blank;

    function automatic logic idx_ext_cur_in_range(input logic [10:0] idx);
        logic [IW-1:0] wide;
        wide = IW'(idx);
        return wide < IW'(CELL_COUNT);
    endfunction

    tci_ram #(
        .WIDTH(16),
        .DEPTH(CELL_COUNT)
    ) u_screen (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign pos     = ADDR_W'(row_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_reg);
    assign idx_ext = IW'(q_out.item.idx);
    assign blank   = {text_color, 8'h00};

    assign back_ctl.clearing = (state_reg == S_CLEAR);
    assign back_ctl.pop      = (state_reg == S_IDLE) && q_out.valid;

    assign out_valid  = out_valid_reg;
    assign column_now = ocol_reg;
    assign row_now    = orow_reg;
    assign read_char  = ochar_reg;
    assign read_color = ocolor_reg;
    assign did_scroll = oscroll_reg;

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        desc_next      = desc_reg;
        to_write_next  = to_write_reg;
        scroll_next    = scroll_reg;
        cur_next       = cur_reg;
        rchar_next     = rchar_reg;
        rcolor_next    = rcolor_reg;
        out_valid_next = out_valid_reg;
        ocol_next      = ocol_reg;
        orow_next      = orow_reg;
        ochar_next     = ochar_reg;
        ocolor_next    = ocolor_reg;
        oscroll_next   = oscroll_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_reg;
        mem_wdata      = blank;
        mem_raddr      = pos;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = 16'h0000;
                fill_next = fill_reg + 1'b1;
                if (fill_reg == LAST_CELL)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_out.valid)
                begin
                    cur_next    = q_out.item;
                    scroll_next = 1'b0;
                    rchar_next  = 8'h00;
                    rcolor_next = 8'h00;
                    unique case (q_out.item.op)
                        OP_READ:
                        begin
                            mem_raddr = idx_ext[ADDR_W-1:0];
                            state_next = S_RD_WAIT;
                        end
                        OP_NEWLINE:
                        begin
                            col_next = '0;
                            if (row_reg == LAST_ROW)
                            begin
                                scroll_next   = 1'b1;
                                src_next      = ADDR_W'(SCREEN_WIDTH);
                                dst_next      = '0;
                                cnt_next      = ADDR_W'(CELL_COUNT - SCREEN_WIDTH);
                                desc_next     = 1'b0;
                                pend_next     = 1'b0;
                                to_write_next = 1'b0;
                                fill_next     = ADDR_W'(CELL_COUNT - SCREEN_WIDTH);
                                state_next    = S_MOVE;
                            end
                            else
                            begin
                                row_next   = row_reg + 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next   = col_reg - 1'b1;
                                state_next = S_BS_GO;
                            end
                            else if (row_reg != '0)
                            begin
                                mem_raddr  = pos - 1'b1;
                                state_next = S_BS_WAIT;
                            end
                            else
                                state_next = S_DONE;
                        end
                        OP_PRINT:
                        begin
                            state_next = S_PR_WAIT;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                if (idx_ext_cur_in_range(cur_reg.idx))
                begin
                    rchar_next  = mem_rdata[7:0] & CHAR_MASK;
                    rcolor_next = mem_rdata[15:8];
                end
                state_next = S_DONE;
            end
            S_BS_WAIT:
            begin
                if (mem_rdata[7:0] != 8'h00)
                begin
                    col_next = LAST_COL;
                    row_next = row_reg - 1'b1;
                end
                state_next = S_BS_GO;
            end
            S_BS_GO:
            begin
                src_next      = pos + 1'b1;
                dst_next      = pos;
                cnt_next      = LAST_CELL - pos;
                desc_next     = 1'b0;
                pend_next     = 1'b0;
                to_write_next = 1'b0;
                fill_next     = LAST_CELL;
                state_next    = S_MOVE;
            end
            S_PR_WAIT:
            begin
                if (mem_rdata[7:0] != 8'h00)
                begin
                    src_next      = LAST_CELL - 1'b1;
                    dst_next      = LAST_CELL;
                    cnt_next      = LAST_CELL - pos;
                    desc_next     = 1'b1;
                    pend_next     = 1'b0;
                    to_write_next = 1'b1;
                    state_next    = S_MOVE;
                end
                else
                    state_next = S_PR_WRITE;
            end
            S_PR_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos;
                mem_wdata = {text_color, cur_reg.ch};
                if (col_reg == LAST_COL)
                begin
                    col_next = '0;
                    if (row_reg == LAST_ROW)
                    begin
                        scroll_next   = 1'b1;
                        src_next      = ADDR_W'(SCREEN_WIDTH);
                        dst_next      = '0;
                        cnt_next      = ADDR_W'(CELL_COUNT - SCREEN_WIDTH);
                        desc_next     = 1'b0;
                        pend_next     = 1'b0;
                        to_write_next = 1'b0;
                        fill_next     = ADDR_W'(CELL_COUNT - SCREEN_WIDTH);
                        state_next    = S_MOVE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = S_DONE;
                end
            end
            S_MOVE:
            begin
                mem_raddr = src_reg;
                pend_next = (cnt_reg != '0);
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    src_next = desc_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = mem_rdata;
                    dst_next  = desc_reg ? dst_reg - 1'b1 : dst_reg + 1'b1;
                end
                if (cnt_reg == '0 && !pend_reg)
                    state_next = to_write_reg ? S_PR_WRITE : S_FILL;
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                fill_next = fill_reg + 1'b1;
                if (fill_reg == LAST_CELL)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ocol_next      = 7'(col_reg);
                    orow_next      = 5'(row_reg);
                    ochar_next     = rchar_reg;
                    ocolor_next    = rcolor_reg;
                    oscroll_next   = scroll_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            col_reg       <= '0;
            row_reg       <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            desc_reg      <= 1'b0;
            to_write_reg  <= 1'b0;
            scroll_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            desc_reg      <= desc_next;
            to_write_reg  <= to_write_next;
            scroll_reg    <= scroll_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        cur_reg     <= cur_next;
        rchar_reg   <= rchar_next;
        rcolor_reg  <= rcolor_next;
        ocol_reg    <= ocol_next;
        orow_reg    <= orow_next;
        ochar_reg   <= ochar_next;
        ocolor_reg  <= ocolor_next;
        oscroll_reg <= oscroll_next;
    end

    `TCI_ASSERT_NOW(a_col_range, 1'b1, col_reg <= LAST_COL)
    `TCI_ASSERT_NOW(a_row_range, 1'b1, row_reg <= LAST_ROW)
    `TCI_ASSERT_NOW(a_write_range, mem_we, mem_waddr <= LAST_CELL)
    `TCI_ASSERT_NEXT(a_done_held, state_reg == S_DONE && out_valid_reg && !out_ready,
                     state_reg == S_DONE)

endmodule

// ----- design/text_console_insert_engine_top.sv -----
// ----------------------------------------------------------------------------
// text_console_insert_engine_top
// text screen with cursor: insert, delete, newline, scroll and cell read
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     mode, char_code, cell_index
// out      output     out_valid / out_ready   column_now, row_now, read_char,
//                                             read_color, did_scroll
// cfg      input      psel/penable/pwrite     paddr, pwdata, prdata
//
// from acceptance to out_valid: a newline without scroll goes straight to
// the done state, a read waits for the ram read data, a print into an empty
// cell reads the cell, then writes it; print, backspace and scroll run one
// cell per cycle through the single write port of the screen ram
// after reset a clearing pass over every cell runs, in_ready stays low
// a result waiting on out_ready stalls the back end, the queue still fills
// ----------------------------------------------------------------------------
module text_console_insert_engine_top
    import tci_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [7:0]         char_code,
    input  logic [10:0]        cell_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         column_now,
    output logic [4:0]         row_now,
    output logic [7:0]         read_char,
    output logic [7:0]         read_color,
    output logic               did_scroll
);

    logic [7:0] color_reg;
    queue_out_t q_out;
    back_ctl_t  back_ctl;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TEXT_COLOR) ? {24'h0, color_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_reg <= COLOR_RESET;
        else if (psel && penable && pwrite && pready && paddr == REG_TEXT_COLOR)
            color_reg <= pwdata[7:0];
    end

    tci_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .char_code (char_code),
        .cell_index(cell_index),
        .back_ctl  (back_ctl),
        .q_out     (q_out)
    );

    tci_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_out     (q_out),
        .back_ctl  (back_ctl),
        .text_color(color_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .column_now(column_now),
        .row_now   (row_now),
        .read_char (read_char),
        .read_color(read_color),
        .did_scroll(did_scroll)
    );

endmodule
